// ===== hw/rtl/mct_pkg.sv =====
package mct_pkg;

   localparam int DATA_W            = 32;
   localparam int LANES             = 4;
   localparam int LANE_IDX_W        = $clog2(LANES);
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   typedef logic [LANES-1:0][DATA_W-1:0] vec_type;

   typedef struct packed {
      op_type                op;
      logic [LANE_IDX_W-1:0] column_index;
   } req_ctl_type;

endpackage

// ===== hw/rtl/mct_mult_stage.sv =====
module mct_mult_stage #(
   parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mct_pkg::req_ctl_type  in_ctl,
   input  mct_pkg::vec_type      in_vec,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [mct_pkg::LANES-1:0][mct_pkg::LANES-1:0][2*mct_pkg::DATA_W-FRAC_BITS-1:0]
                                 out_terms
);

   localparam int PROD_W = 2 * mct_pkg::DATA_W;
   localparam int TERM_W = PROD_W - FRAC_BITS;

   logic                  s0_valid_ff;
   mct_pkg::req_ctl_type  s0_ctl_ff;
   mct_pkg::vec_type      s0_vec_ff;
   mct_pkg::vec_type      matrix_ff [mct_pkg::LANES];

   logic                  s1_valid_ff, s1_valid_in;
   logic [mct_pkg::LANES-1:0][mct_pkg::LANES-1:0][TERM_W-1:0] terms_ff, terms_in;
   logic signed [PROD_W-1:0] prod [mct_pkg::LANES][mct_pkg::LANES];

   logic s0_adv, s1_ready, s0_is_load;

   assign s0_is_load = (s0_ctl_ff.op == mct_pkg::OP_LOAD);
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign s0_adv     = s0_valid_ff && (s0_is_load || s1_ready);
   assign in_ready   = !s0_valid_ff || s0_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s0_ctl_ff <= in_ctl;
         s0_vec_ff <= in_vec;
      end
   end

   // matrix_ff[column][row]; written in order as a load leaves stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < mct_pkg::LANES; c++) begin
            matrix_ff[c] <= '0;
         end
      end else if (s0_adv && s0_is_load) begin
         matrix_ff[s0_ctl_ff.column_index] <= s0_vec_ff;
      end
   end

   // row r, column c: floor(m[c][r] * v[c] / 2^FRAC_BITS)
   always_comb begin
      for (int r = 0; r < mct_pkg::LANES; r++) begin
         for (int c = 0; c < mct_pkg::LANES; c++) begin
            prod[r][c] = PROD_W'($signed(matrix_ff[c][r])) * PROD_W'($signed(s0_vec_ff[c]));
            terms_in[r][c] = prod[r][c][PROD_W-1:FRAC_BITS];
         end
      end
   end

   assign s1_valid_in = s0_valid_ff && !s0_is_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         terms_ff <= terms_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_terms = terms_ff;

   a_load_writes_column: assert property (@(posedge clock) disable iff (reset)
      (s0_adv && s0_is_load) |=>
         matrix_ff[$past(s0_ctl_ff.column_index)] == $past(s0_vec_ff))
      else $error("load did not update the matrix column");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> s1_valid_ff)
      else $error("product stage dropped a stalled item");

endmodule

// ===== hw/rtl/mct_sum_stage.sv =====
module mct_sum_stage #(
   parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [mct_pkg::LANES-1:0][mct_pkg::LANES-1:0][2*mct_pkg::DATA_W-FRAC_BITS-1:0]
                             in_terms,
   output logic              out_valid,
   input  logic              out_ready,
   output mct_pkg::vec_type  out_vec,
   output logic              out_sat
);

   localparam int DW     = mct_pkg::DATA_W;
   localparam int TERM_W = 2 * DW - FRAC_BITS;
   localparam int PAIR_W = TERM_W + 1;
   localparam int SUM_W  = TERM_W + 2;
   localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic                     s2_valid_ff;
   logic signed [PAIR_W-1:0] pair_ff [mct_pkg::LANES][2];
   logic signed [PAIR_W-1:0] pair_in [mct_pkg::LANES][2];

   logic                     s3_valid_ff;
   mct_pkg::vec_type         vec_ff, vec_in;
   logic                     sat_ff, sat_in;
   logic signed [SUM_W-1:0]  sum [mct_pkg::LANES];
   logic [mct_pkg::LANES-1:0] clip;

   logic s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;

   always_comb begin
      for (int r = 0; r < mct_pkg::LANES; r++) begin
         for (int h = 0; h < 2; h++) begin
            pair_in[r][h] = PAIR_W'($signed(in_terms[r][2*h]))
                          + PAIR_W'($signed(in_terms[r][2*h+1]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         pair_ff <= pair_in;
      end
   end

   // row sum, then clip to 32 signed bits
   always_comb begin
      for (int r = 0; r < mct_pkg::LANES; r++) begin
         sum[r]  = SUM_W'(pair_ff[r][0]) + SUM_W'(pair_ff[r][1]);
         clip[r] = !((&sum[r][SUM_W-1:DW-1]) || !(|sum[r][SUM_W-1:DW-1]));
         if (clip[r]) begin
            vec_in[r] = sum[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            vec_in[r] = sum[r][DW-1:0];
         end
      end
      sat_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         vec_ff <= vec_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_vec   = vec_ff;
   assign out_sat   = sat_ff;

   a_sat_means_clipped: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && sat_ff) |->
         (vec_ff[0] == SAT_MAX || vec_ff[0] == SAT_MIN ||
          vec_ff[1] == SAT_MAX || vec_ff[1] == SAT_MIN ||
          vec_ff[2] == SAT_MAX || vec_ff[2] == SAT_MIN ||
          vec_ff[3] == SAT_MAX || vec_ff[3] == SAT_MIN))
      else $error("saturated flag set without a clipped lane");

   a_s2_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> s2_valid_ff)
      else $error("pair-sum stage dropped a stalled item");

endmodule

// ===== hw/rtl/matrix_column_transform_4x4.sv =====
// 4x4 matrix column transform, signed fixed point with FRAC_BITS fraction bits.
// req channel: req_tuser[0] = op (0 load column, 1 transform), req_tuser[2:1] =
// column index for a load; req_tdata carries x, y, z, w, 32 bits each.
// A load writes one column of the stored matrix and returns nothing. A transform
// returns M * (x,y,z,w) on the rsp channel: rsp_tdata holds the four saturated
// row sums, rsp_tuser[0] is set if any sum was clipped.
// Throughput: one transfer per cycle on both sides while rsp_tready is high;
// loads and transforms mix freely and a transform sees every load accepted
// before it. A transform passes the input register, 16-multiplier product
// stage, pair adders and final add/clip before it reaches rsp. Reset clears the
// matrix to zero and empties the pipeline. When the receiver stalls, results
// hold in the output register and stages behind it keep filling bubbles;
// req_tready drops once every stage is full and stage 0 holds a transform.
module matrix_column_transform_4x4 #(
   parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // in_x, in_y, in_z, in_w
   input  logic [2:0]   req_tuser,   // op, column_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic [0:0]   rsp_tuser    // saturated
);

   localparam int TERM_W = 2 * mct_pkg::DATA_W - FRAC_BITS;

   mct_pkg::req_ctl_type req_ctl;
   mct_pkg::vec_type     req_vec;
   mct_pkg::vec_type     rsp_vec;
   logic                 rsp_sat;

   logic mid_valid, mid_ready;
   logic [mct_pkg::LANES-1:0][mct_pkg::LANES-1:0][TERM_W-1:0] mid_terms;

   assign req_ctl.op           = mct_pkg::op_type'(req_tuser[0]);
   assign req_ctl.column_index = req_tuser[2:1];
   assign req_vec              = req_tdata;

   mct_mult_stage #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ctl    (req_ctl),
      .in_vec    (req_vec),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_terms (mid_terms)
   );

   mct_sum_stage #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_terms  (mid_terms),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vec   (rsp_vec),
      .out_sat   (rsp_sat)
   );

   assign rsp_tdata    = rsp_vec;
   assign rsp_tuser[0] = rsp_sat;

endmodule

// ===== tb/matrix_column_transform_4x4_tb.sv =====
`timescale 1ns / 1ps

module matrix_column_transform_4x4_tb;

   localparam int          FRAC        = mct_pkg::FRAC_BITS_DEFAULT;
   localparam int unsigned IDLE_PCT    = 28;
   localparam int          STALL_LIMIT = 2000;
   localparam int          TAIL_CYCLES = 12;
   localparam int          MAX_REPORTS = 20;

   localparam logic [31:0] MAXV    = 32'h7fff_ffff;
   localparam logic [31:0] MINV    = 32'h8000_0000;
   localparam logic [31:0] ONE     = 32'h0001_0000;
   localparam logic [31:0] NEG_LSB = 32'hffff_ffff;

   localparam longint SUM_MAX = (longint'(1) <<< 31) - 1;
   localparam longint SUM_MIN = -(longint'(1) <<< 31);

   typedef struct packed {
      mct_pkg::vec_type lane;
      logic             sat;
   } xform_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // in_x, in_y, in_z, in_w
   logic [2:0]   req_tuser;   // op, column_index
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // out_x, out_y, out_z, out_w
   logic [0:0]   rsp_tuser;   // saturated

   logic [31:0]      matrix_model [16];
   xform_result_type expected_results [$];
   xform_result_type expected_head;
   mct_pkg::vec_type got_vec;
   bit               no_idle = 1'b0;
   int               mismatches = 0;
   int               load_count = 0;
   int               xform_count = 0;
   int               sat_count = 0;
   int               stall_cycles;
   string            lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};

   matrix_column_transform_4x4 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic xform_result_type predict_transform(mct_pkg::vec_type v);
      xform_result_type res;
      longint           acc;
      longint           prod;
      res.sat = 1'b0;
      for (int r = 0; r < 4; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) begin
            prod = longint'($signed(matrix_model[c*4+r])) * longint'($signed(v[c]));
            acc += prod >>> FRAC;
         end
         if (acc > SUM_MAX) begin
            res.lane[r] = MAXV;
            res.sat     = 1'b1;
         end else if (acc < SUM_MIN) begin
            res.lane[r] = MINV;
            res.sat     = 1'b1;
         end else begin
            res.lane[r] = acc[31:0];
         end
      end
      return res;
   endfunction

   function automatic mct_pkg::vec_type vec4(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic [31:0] w);
      return {w, z, y, x};
   endfunction

   function automatic logic [31:0] rand_elem();
      int unsigned pick;
      pick = $urandom_range(11);
      case (pick)
         0: begin
            return MAXV;
         end
         1: begin
            return MINV;
         end
         2: begin
            return 32'($urandom_range(2)) - 32'd1;
         end
         3, 4, 5, 6: begin
            return $urandom;
         end
         default: begin
            // roughly -4.0 .. +4.0
            return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
         end
      endcase
   endfunction

   function automatic mct_pkg::vec_type random_vec();
      return vec4(rand_elem(), rand_elem(), rand_elem(), rand_elem());
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_REPORTS)
         $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_transfer(mct_pkg::op_type op, logic [1:0] col,
                                mct_pkg::vec_type v);
      xform_result_type res;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= {col, op};
      do @(posedge clock); while (!req_tready);
      if (op == mct_pkg::OP_LOAD) begin
         for (int r = 0; r < 4; r++)
            matrix_model[col*4+r] = v[r];
         load_count++;
      end else begin
         res = predict_transform(v);
         expected_results.push_back(res);
         xform_count++;
         if (res.sat)
            sat_count++;
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_reset_matrix();
      send_transfer(mct_pkg::OP_XFORM, 2'd3, vec4(MAXV, MINV, NEG_LSB, ONE));
      send_transfer(mct_pkg::OP_XFORM, 2'd0, random_vec());
   endtask

   task automatic test_directed();
      // identity
      for (int c = 0; c < 4; c++)
         send_transfer(mct_pkg::OP_LOAD, 2'(c), vec4(c == 0 ? ONE : 0, c == 1 ? ONE : 0,
                                                    c == 2 ? ONE : 0, c == 3 ? ONE : 0));
      send_transfer(mct_pkg::OP_XFORM, 2'd1, vec4(MAXV, MINV, ONE, NEG_LSB));
      // saturation both ways
      send_transfer(mct_pkg::OP_LOAD, 2'd2, vec4(MAXV, MAXV, MAXV, MAXV));
      send_transfer(mct_pkg::OP_LOAD, 2'd3, vec4(MINV, MINV, MINV, MINV));
      send_transfer(mct_pkg::OP_XFORM, 2'd0, vec4(0, 0, MAXV, 0));
      send_transfer(mct_pkg::OP_XFORM, 2'd0, vec4(0, 0, 0, MAXV));
      send_transfer(mct_pkg::OP_XFORM, 2'd2, vec4(0, 0, 0, MINV));
      send_transfer(mct_pkg::OP_XFORM, 2'd3, vec4(0, 0, MAXV, MAXV));
      send_transfer(mct_pkg::OP_XFORM, 2'd1, vec4(MAXV, MINV, MINV, MINV));
      // floor on negative products
      send_transfer(mct_pkg::OP_LOAD, 2'd0, vec4(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB));
      send_transfer(mct_pkg::OP_LOAD, 2'd1, vec4(32'd1, 32'd1, 32'd1, 32'd1));
      send_transfer(mct_pkg::OP_XFORM, 2'd0, vec4(32'd1, 32'd1, 0, 0));
      // reload of the same column, last load wins
      send_transfer(mct_pkg::OP_LOAD, 2'd3, random_vec());
      send_transfer(mct_pkg::OP_LOAD, 2'd3, vec4(ONE, NEG_LSB, MAXV, MINV));
      send_transfer(mct_pkg::OP_XFORM, 2'd2, vec4(0, 0, 0, ONE));
      send_transfer(mct_pkg::OP_XFORM, 2'd3, random_vec());
   endtask

   task automatic test_drain_pause();
      send_transfer(mct_pkg::OP_LOAD, 2'd1, random_vec());
      send_transfer(mct_pkg::OP_XFORM, 2'd0, random_vec());
      send_transfer(mct_pkg::OP_XFORM, 2'd1, random_vec());
      wait_drain();
      send_transfer(mct_pkg::OP_XFORM, 2'd2, random_vec());
      send_transfer(mct_pkg::OP_LOAD, 2'd0, random_vec());
      send_transfer(mct_pkg::OP_XFORM, 2'd3, random_vec());
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned sent;
      int unsigned n;
      logic [1:0]  base;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            // full matrix load in a random column order, then a burst of vectors
            base = 2'($urandom_range(3));
            for (int c = 0; c < 4; c++)
               send_transfer(mct_pkg::OP_LOAD, 2'(c) ^ base, random_vec());
            n = $urandom_range(1, 6);
            repeat (n)
               send_transfer(mct_pkg::OP_XFORM, 2'($urandom_range(3)), random_vec());
            sent += 4 + n;
         end else begin
            send_transfer(mct_pkg::op_type'($urandom_range(1)), 2'($urandom_range(3)),
                          random_vec());
            sent++;
         end
      end
   endtask

   task automatic test_back_to_back(int unsigned count);
      no_idle = 1'b1;
      test_random_traffic(count);
      wait_drain();
      no_idle = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], '0);
         end else begin
            expected_head = expected_results.pop_front();
            got_vec       = rsp_tdata;
            for (int r = 0; r < 4; r++)
               if (got_vec[r] !== expected_head.lane[r])
                  report_mismatch(lane_name[r], got_vec[r], expected_head.lane[r]);
            if (rsp_tuser[0] !== expected_head.sat)
               report_mismatch("saturated", 32'(rsp_tuser[0]), 32'(expected_head.sat));
         end
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("matrix_column_transform_4x4 test failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      for (int i = 0; i < 16; i++)
         matrix_model[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_matrix();
      test_directed();
      test_drain_pause();
      test_random_traffic(430);
      wait_drain();
      test_back_to_back(160);
      test_random_traffic(130);

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d column loads and %0d transforms, %0d of them clipped,",
               load_count, xform_count, sat_count);
      $display("with random stalls on both channels and one back-to-back stretch.");
      if (mismatches == 0)
         $display("matrix_column_transform_4x4 test passed");
      else
         $display("matrix_column_transform_4x4 test failed");
      $finish;
   end

endmodule
